[rtl/core/mh64a_pkg.sv]
// ----------------------------------------------------------------------------
// mh64a_pkg
// Shared constants and types for the streaming MurmurHash64A block.
// ----------------------------------------------------------------------------
package mh64a_pkg;

  // Mixing multiplier and shift of MurmurHash64A
  localparam logic [63:0] MIX_MUL    = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [63:0] SEED_RESET = 64'h00000000e17a1465;

  // Configuration port: 64-bit registers at 8-byte spacing
  localparam int unsigned CFG_AW   = 4;
  localparam logic        REG_SEED = 1'b0;  // register index 0 (paddr[3])

  // Byte count of a full chunk; larger counts are clamped to it
  localparam logic [3:0] FULL_BYTES = 4'd8;

  // Request to the shared multiply unit
  typedef struct packed {
    logic        start;
    logic [63:0] opnd;
  } mul_req_t;

  // Response from the shared multiply unit
  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mul_rsp_t;

endpackage

[rtl/core/murmur_hash64a_stream.sv]
// ----------------------------------------------------------------------------
// murmur_hash64a_stream
// Streaming MurmurHash64A over 8-byte little-endian message chunks.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are chunks (in_first, in_total_length, in_data_word,
//   in_valid_bytes, in_last), taken when in_valid is high and in_stall low.
//   A chunk with in_last set yields one out_hash_value item on the out_
//   channel; other chunks yield nothing. Chunks arriving with no open
//   message and in_first low are dropped.
//   All multiplies go through one 32x32 multiplier: each 64-bit multiply by
//   the mixing constant is issued, forms three partial products, accumulates
//   them and hands the result back. A full chunk needs 3 multiplies, a first
//   chunk adds one for the seed, a last chunk one for finalization.
//   in_stall is high while a chunk is being worked on.
//   A finished hash sits in the output register; the next chunk is accepted
//   while it waits. If the receiver stalls, a later result waits internally
//   and the input stays stalled until the output register frees up.
//   Reset (rst_n low, synchronous) closes any open message, empties the output
//   and restores hash_seed to its default. The user must write hash_seed over
//   APB at byte address 0 only while the block is idle; no logic enforces it.
// ----------------------------------------------------------------------------
module murmur_hash64a_stream
  import mh64a_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input chunks
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_first,
  input  logic [31:0]       in_total_length,
  input  logic [63:0]       in_data_word,
  input  logic [3:0]        in_valid_bytes,
  input  logic              in_last,
  // results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_hash_value,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [63:0] seed_r;
  logic        cfg_wr;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_RESET;
    end else if (cfg_wr && (cfg_paddr[3] == REG_SEED)) begin
      seed_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = (cfg_paddr[3] == REG_SEED) ? seed_r : 64'h0;

  mh64a_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .seed            (seed_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first        (in_first),
    .in_total_length (in_total_length),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hash_value  (out_hash_value),
    .mreq            (mreq),
    .mrsp            (mrsp)
  );

  mh64a_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

endmodule

[rtl/core/mh64a_mul.sv]
// ----------------------------------------------------------------------------
// mh64a_mul
// Iterative multiply by MIX_MUL modulo 2^64 using one 32x32 multiplier.
// ----------------------------------------------------------------------------
module mh64a_mul
  import mh64a_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic [1:0]  ph_r;
  logic [63:0] a_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [31:0] a_part;
  logic [31:0] m_part;

  // Partial product select: lo*lo, hi*lo, lo*hi
  always_comb begin
    a_part = (ph_r == 2'd1) ? a_r[63:32] : a_r[31:0];
    m_part = (ph_r == 2'd2) ? MIX_MUL[63:32] : MIX_MUL[31:0];
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        ph_r   <= 2'd0;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: product registered before it is accumulated
  always_ff @(posedge clk) begin
    if (req.start) a_r <= req.opnd;
    prod_r <= {32'h0, a_part} * {32'h0, m_part};
    if (busy_r) begin
      case (ph_r)
        2'd1:    acc_r <= prod_r;
        2'd2,
        2'd3:    acc_r <= acc_r + {prod_r[31:0], 32'h0};
        default: acc_r <= acc_r;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

[rtl/core/mh64a_seq.sv]
// ----------------------------------------------------------------------------
// mh64a_seq
// Per-item sequencer: seeding, chunk mix, tail, finalization and result.
// ----------------------------------------------------------------------------
module mh64a_seq
  import mh64a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [63:0] seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first,
  input  logic [31:0] in_total_length,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  output mul_req_t    mreq,
  input  mul_rsp_t    mrsp
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEED, S_DISP, S_K1, S_K2, S_H, S_FIN, S_OUT
  } state_t;

  state_t      state_r;
  logic        in_msg_r;
  logic [63:0] h_r;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        last_r;
  logic [63:0] fin_r;
  logic        out_valid_r;
  logic [63:0] out_hash_r;
  logic        start_r;
  logic        start_nxt;
  logic [63:0] opnd_r;

  logic        accept;
  logic [3:0]  cnt_clamp;
  logic [63:0] tail_mask;
  logic [63:0] res_xs;
  logic [63:0] h_xs;
  logic        full_chunk;

  assign accept = in_valid && (state_r == S_IDLE);

  // Byte count clamp, tail mask and the shift-xor helpers
  always_comb begin
    cnt_clamp = (in_valid_bytes > FULL_BYTES) ? FULL_BYTES : in_valid_bytes;
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (4'(i) < cnt_r) ? 8'hff : 8'h00;
    end
    res_xs     = mrsp.res ^ (mrsp.res >> MIX_SHIFT);
    h_xs       = h_r ^ (h_r >> MIX_SHIFT);
    full_chunk = !last_r || (cnt_r == FULL_BYTES);
  end

  // Multiply issue: one pulse whenever a new operand is loaded
  assign start_nxt = (accept && in_first) || (state_r == S_DISP) ||
                     (mrsp.done && ((state_r == S_K1) || (state_r == S_K2) ||
                                    ((state_r == S_H) && last_r)));

  // State, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_msg_r    <= 1'b0;
      h_r         <= '0;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      start_r <= start_nxt;
      if (out_valid_r && !out_stall && (state_r != S_OUT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            word_r <= in_data_word;
            cnt_r  <= cnt_clamp;
            last_r <= in_last;
            if (in_first) begin
              in_msg_r <= 1'b1;
              opnd_r   <= {32'h0, in_total_length};
              state_r  <= S_SEED;
            end else if (in_msg_r) begin
              state_r <= S_DISP;
            end
          end
        end
        S_SEED: begin
          if (mrsp.done) begin
            h_r     <= seed ^ mrsp.res;
            state_r <= S_DISP;
          end
        end
        // Choose full mix, tail or straight finalization
        S_DISP: begin
          if (full_chunk) begin
            opnd_r  <= word_r;
            state_r <= S_K1;
          end else if (cnt_r != 4'd0) begin
            opnd_r  <= h_r ^ (word_r & tail_mask);
            state_r <= S_H;
          end else begin
            opnd_r  <= h_xs;
            state_r <= S_FIN;
          end
        end
        S_K1: begin
          if (mrsp.done) begin
            opnd_r  <= res_xs;
            state_r <= S_K2;
          end
        end
        S_K2: begin
          if (mrsp.done) begin
            opnd_r  <= h_r ^ mrsp.res;
            state_r <= S_H;
          end
        end
        S_H: begin
          if (mrsp.done) begin
            h_r <= mrsp.res;
            if (last_r) begin
              opnd_r  <= res_xs;
              state_r <= S_FIN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (mrsp.done) begin
            fin_r    <= res_xs;
            in_msg_r <= 1'b0;
            state_r  <= S_OUT;
          end
        end
        // Wait for the output register to free up
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_hash_r  <= fin_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;
  assign mreq.start     = start_r;
  assign mreq.opnd      = opnd_r;

endmodule

[rtl/core/mh64a_chk.sv]
// ----------------------------------------------------------------------------
// mh64a_chk
// Port-level checks for murmur_hash64a_stream, bound to the top level.
// ----------------------------------------------------------------------------
module mh64a_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_first,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_hash_value
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hash_value))
    else $error("stalled result changed");

  // Reset empties the output
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A first chunk keeps the block busy for its seed multiply
  a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_first |=> in_stall ##1 in_stall)
    else $error("first chunk not held busy");

  // No result can appear right after a chunk is taken
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too early");

endmodule

bind murmur_hash64a_stream mh64a_chk u_mh64a_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_first       (in_first),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hash_value (out_hash_value)
);

[tb/sv/murmur_hash64a_stream_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur_hash64a_stream_chk
// Watches the chunk, hash and APB channels of the streaming MurmurHash64A
// block. It keeps its own accumulator and seed and computes the hash of each
// message as it is accepted. Every accepted hash is compared with the oldest
// outstanding expected hash.
// ----------------------------------------------------------------------------
module murmur_hash64a_stream_chk
  import mh64a_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_first,
  input  logic [31:0]       in_total_length,
  input  logic [63:0]       in_data_word,
  input  logic [3:0]        in_valid_bytes,
  input  logic              in_last,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [63:0]       out_hash_value,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [63:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                hashes_pending
);

  logic [63:0] seed;
  logic [63:0] acc;
  logic        msg_open;
  logic [63:0] k;
  logic [63:0] want;
  logic [3:0]  nbytes;
  logic [63:0] hash_queue[$];

  always @(posedge clk) begin
    if (!rst_n) begin
      seed     = SEED_RESET;
      acc      = '0;
      msg_open = 1'b0;
      hash_queue.delete();
    end else begin
      // seed register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {REG_SEED, 3'b000}) begin
        seed = cfg_pwdata;
      end

      // finished hash leaving the block
      if (out_valid && !out_stall) begin
        if (hash_queue.size() == 0) begin
          $error("hash_value: no hash expected, actual %h", out_hash_value);
          fail_count++;
        end else begin
          want = hash_queue.pop_front();
          if (out_hash_value !== want) begin
            $error("hash_value mismatch: expected %h, actual %h", want, out_hash_value);
            fail_count++;
          end
        end
      end

      // chunk entering the block; chunks outside a message are dropped
      if (in_valid && !in_stall && (in_first || msg_open)) begin
        if (in_first) begin
          acc = seed ^ ({32'd0, in_total_length} * MIX_MUL);
        end
        nbytes = (in_valid_bytes > FULL_BYTES) ? FULL_BYTES : in_valid_bytes;
        if (!in_last || nbytes == FULL_BYTES) begin
          // full chunk: scramble then fold
          k   = in_data_word * MIX_MUL;
          k   = k ^ (k >> MIX_SHIFT);
          k   = k * MIX_MUL;
          acc = (acc ^ k) * MIX_MUL;
        end else if (nbytes != 4'd0) begin
          // tail: only the low bytes count
          acc = (acc ^ (in_data_word & ((64'd1 << (8 * nbytes)) - 64'd1))) * MIX_MUL;
        end
        msg_open = !in_last;
        if (in_last) begin
          k = acc ^ (acc >> MIX_SHIFT);
          k = k * MIX_MUL;
          k = k ^ (k >> MIX_SHIFT);
          hash_queue.push_back(k);
        end
      end
    end
    hashes_pending <= hash_queue.size();
  end

endmodule

[tb/sv/murmur_hash64a_stream_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur_hash64a_stream_tb
// Drives chunked messages into the streaming MurmurHash64A block under
// several seeds, with random gaps on the chunk side and random stalls on
// the hash side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module murmur_hash64a_stream_tb;
  import mh64a_pkg::*;

  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 110;
  localparam int SETTLE       = 80;
  localparam int CYCLE_LIMIT  = 400000;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic              in_first        = 1'b0;
  logic [31:0]       in_total_length = '0;
  logic [63:0]       in_data_word    = '0;
  logic [3:0]        in_valid_bytes  = '0;
  logic              in_last         = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [63:0]       out_hash_value;
  logic              cfg_psel        = 1'b0;
  logic              cfg_penable     = 1'b0;
  logic              cfg_pwrite      = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr       = '0;
  logic [63:0]       cfg_pwdata      = '0;
  logic [63:0]       cfg_prdata;
  logic              cfg_pready;

  int   fail_count;
  int   hashes_pending;
  int   cycles = 0;
  logic calm = 1'b0;    // no gaps and no stalls while set
  logic msg_open = 1'b0;
  int   sent;

  always #10 clk = ~clk;

  murmur_hash64a_stream u_top (.*);

  murmur_hash64a_stream_chk u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .in_first, .in_total_length,
    .in_data_word, .in_valid_bytes, .in_last, .out_valid, .out_stall,
    .out_hash_value, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_pready, .fail_count, .hashes_pending
  );

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("murmur_hash64a_stream_tb: FAIL");
      $finish;
    end
  end

  // hash side: random stall ahead of each item
  initial begin : hash_sink
    int gap;
    forever begin
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // one chunk, after a random gap; returns at the edge that takes it
  task automatic push_chunk(input logic first, input logic [31:0] len,
                            input logic [63:0] word, input logic [3:0] nbytes,
                            input logic last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first        <= first;
    in_total_length <= len;
    in_data_word    <= word;
    in_valid_bytes  <= nbytes;
    in_last         <= last;
    do @(posedge clk); while (in_stall);
    if (first || msg_open) sent++;
    if (first) msg_open = 1'b1;
    if (last) msg_open = 1'b0;
  endtask

  // let every expected hash out, then give in-flight work time to finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hashes_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of the seed: setup then access
  task automatic write_seed(input logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {REG_SEED, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // well-formed message of nbytes bytes with random content
  task automatic send_message(input int nbytes);
    int          nchunks;
    int          tail;
    logic [31:0] len;
    logic [3:0]  cnt;
    logic        is_last;
    tail    = nbytes % 8;
    nchunks = (tail != 0 || nbytes == 0) ? nbytes / 8 + 1 : nbytes / 8;
    len     = ($urandom_range(0, 9) == 0) ? $urandom : 32'(nbytes);
    for (int i = 0; i < nchunks; i++) begin
      is_last = (i == nchunks - 1);
      cnt     = (is_last && (tail != 0 || nbytes == 0)) ? 4'(tail) : FULL_BYTES;
      // count is ignored on inner chunks and saturates on a full last one
      if (!is_last && $urandom_range(0, 7) == 0) cnt = 4'($urandom_range(0, 15));
      if (is_last && cnt == FULL_BYTES && $urandom_range(0, 3) == 0)
        cnt = 4'($urandom_range(9, 15));
      push_chunk(i == 0, (i == 0) ? len : $urandom, {$urandom, $urandom}, cnt, is_last);
    end
  endtask

  initial begin : stimulus
    logic [63:0] seeds[PHASES];
    int          pick;
    seeds[0] = SEED_RESET;
    seeds[1] = '0;
    seeds[2] = '1;
    seeds[3] = {$urandom, $urandom};
    seeds[4] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed chunks under the reset seed
    push_chunk(1'b1, 32'd0, {$urandom, $urandom}, 4'd0, 1'b1);          // empty message
    push_chunk(1'b1, 32'd1, 64'hffff_ffff_ffff_ffab, 4'd1, 1'b1);        // garbage above tail
    push_chunk(1'b1, 32'hffff_ffff, '1, 4'd7, 1'b1);                     // longest tail
    push_chunk(1'b1, 32'd8, '0, FULL_BYTES, 1'b1);                       // full last chunk
    push_chunk(1'b1, 32'd8, '1, 4'd15, 1'b1);                            // oversized count
    push_chunk(1'b0, 32'd5, {$urandom, $urandom}, 4'd3, 1'b1);           // no open message
    push_chunk(1'b1, 32'd11, {$urandom, $urandom}, 4'd3, 1'b0);          // short inner chunk
    push_chunk(1'b0, 32'd0, {$urandom, $urandom}, 4'd3, 1'b1);
    push_chunk(1'b1, 32'd24, {$urandom, $urandom}, FULL_BYTES, 1'b0);    // restart while open
    push_chunk(1'b1, 32'd16, {$urandom, $urandom}, FULL_BYTES, 1'b0);
    push_chunk(1'b0, 32'd0, {$urandom, $urandom}, FULL_BYTES, 1'b1);
    push_chunk(1'b1, 32'd3, '1, FULL_BYTES, 1'b0);                       // length mismatch
    push_chunk(1'b0, '1, '0, FULL_BYTES, 1'b0);
    push_chunk(1'b0, 32'd0, {$urandom, $urandom}, 4'd5, 1'b1);
    push_chunk(1'b1, 32'd9, {$urandom, $urandom}, 4'd0, 1'b0);           // zero count, inner
    push_chunk(1'b0, 32'd0, {$urandom, $urandom}, 4'd1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        write_seed(seeds[p]);
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        calm = (p == 2) || ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          // stray chunk; dropped unless a broken message is still open
          push_chunk(1'b0, $urandom, {$urandom, $urandom},
                     4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else if (pick < 12) begin
          // broken message: opened and left for the next one to abandon
          push_chunk(1'b1, $urandom, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                     1'b0);
          repeat ($urandom_range(0, 3))
            push_chunk(1'b0, $urandom, {$urandom, $urandom}, FULL_BYTES, 1'b0);
        end else if (pick < 20) begin
          send_message($urandom_range(49, 160));
        end else begin
          send_message($urandom_range(0, 48));
        end
      end
    end

    calm = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("murmur_hash64a_stream_tb: PASS");
    end else begin
      $display("murmur_hash64a_stream_tb: FAIL");
    end
    $finish;
  end

endmodule
